// ===== src/fud_pkg.sv =====
// Shared types, character codes and helpers of the form/percent decoder.
// No dependencies; every other file in src imports it.
package fud_pkg;

	localparam int MaxRes = 5;                  // most results a plan can hold; one input byte causes at most four
	localparam int CntW   = $clog2(MaxRes + 1);
	localparam int QDepth = 4;                  // plan queue entries
	localparam int QPtrW  = $clog2(QDepth);

	localparam logic [7:0] ChAmp    = 8'h26;    // '&'
	localparam logic [7:0] ChSemi   = 8'h3B;    // ';'
	localparam logic [7:0] ChPlus   = 8'h2B;    // '+'
	localparam logic [7:0] ChPct    = 8'h25;    // '%'
	localparam logic [7:0] ChEq     = 8'h3D;    // '='
	localparam logic [7:0] ChOne    = 8'h31;    // '1'
	localparam logic [7:0] ChSpace  = 8'h20;    // ' '
	localparam logic [7:0] CaseMask = 8'hDF;    // clears the lower-case bit
	localparam logic [7:0] HexOff   = 8'd55;    // 'A' - 10
	localparam logic [7:0] DigOff   = 8'd16;    // '0' after the case mask

	typedef struct packed {
		logic       pend;
		logic       val;
		logic       has;
		logic [7:0] data;
	} result_t;

	typedef struct packed {
		result_t [MaxRes-1:0] res;
		logic [CntW-1:0]      cnt;
	} plan_t;

	typedef struct packed {
		logic  valid;
		plan_t head;
	} q_status_t;

	function automatic logic is_hex(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [7:0] u;
		u = c & CaseMask;
		if (u < 8'd32)
			return 4'(u - DigOff);
		return 4'(u - HexOff);
	endfunction

	function automatic result_t mk_res(logic [7:0] b, logic has, logic val, logic pend);
		result_t r;
		r.data = has ? b : 8'h00;
		r.has  = has;
		r.val  = val;
		r.pend = pend;
		return r;
	endfunction

	function automatic plan_t put(plan_t p, result_t r);
		plan_t o;
		o = p;
		if (o.cnt < CntW'(MaxRes)) begin
			o.res[o.cnt] = r;
			o.cnt        = o.cnt + CntW'(1);
		end
		return o;
	endfunction

endpackage

// ===== src/fud_front.sv =====
// Front end: takes raw bytes, tracks escape and pair state, and builds the
// list of results for each byte. Depends on fud_pkg.
module fud_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic          cfg_data,
	input  logic          acc,
	input  logic [7:0]    data_byte,
	input  logic          last,
	output logic          push,
	output fud_pkg::plan_t plan
);
	import fud_pkg::*;

	typedef enum logic [2:0] {
		ESC_NONE = 3'b001,
		ESC_PCT  = 3'b010,
		ESC_DIG  = 3'b100
	} esc_t;

	logic       form_mode_q;
	esc_t       esc_q;
	logic [7:0] held_q;
	logic       saw_eq_q;
	logic       prev_sep_q;
	logic       at_start_q;

	esc_t       ph_n;
	logic [7:0] hd_n;
	logic       se_n;
	logic       ps_n;
	logic       st_n;

	function automatic plan_t flush_p(plan_t p, esc_t ph, logic [7:0] hd, logic v);
		plan_t o;
		o = p;
		if (ph == ESC_PCT) begin
			o = put(o, mk_res(ChPct, 1'b1, v, 1'b0));
		end else if (ph == ESC_DIG) begin
			o = put(o, mk_res(ChPct, 1'b1, v, 1'b0));
			o = put(o, mk_res(hd, 1'b1, v, 1'b0));
		end
		return o;
	endfunction

	function automatic plan_t end_pair(plan_t p, logic se);
		if (se)
			return put(p, mk_res(8'h00, 1'b0, 1'b1, 1'b1));
		return put(p, mk_res(ChOne, 1'b1, 1'b1, 1'b1));
	endfunction

	always_comb begin
		plan_t      p;
		logic       is_sep;
		logic       do_fa;
		logic       va;
		logic       do_feed;
		logic [7:0] fc;
		logic       fv;
		logic       do_fb;
		logic       ep1;
		logic       ep2;
		logic       set_eq;
		logic       skip;
		p       = '0;
		ph_n    = esc_q;
		hd_n    = held_q;
		se_n    = saw_eq_q;
		is_sep  = (data_byte == ChAmp) || (data_byte == ChSemi);
		do_fa   = 1'b0;
		va      = 1'b0;
		do_feed = 1'b0;
		fc      = data_byte;
		fv      = 1'b0;
		do_fb   = 1'b0;
		ep1     = 1'b0;
		ep2     = 1'b0;
		set_eq  = 1'b0;
		skip    = 1'b0;

		// choose the steps this byte runs, in order
		priority if (!form_mode_q) begin
			do_feed = 1'b1;
			do_fb   = last;
		end else if (is_sep) begin
			do_fa = !prev_sep_q || at_start_q;
			va    = saw_eq_q;
			ep1   = do_fa;
			ep2   = last;
		end else begin
			if (data_byte == ChEq && !saw_eq_q) begin
				do_fa  = 1'b1;
				set_eq = 1'b1;
			end else begin
				do_feed = 1'b1;
				fc      = (data_byte == ChPlus) ? ChSpace : data_byte;
				fv      = saw_eq_q;
			end
			do_fb = last;
			ep1   = last;
		end

		if (do_fa) begin
			p    = flush_p(p, ph_n, hd_n, va);
			ph_n = ESC_NONE;
		end
		if (set_eq)
			se_n = 1'b1;

		if (do_feed) begin
			if (ph_n == ESC_PCT) begin
				if (is_hex(fc)) begin
					hd_n = fc;
					ph_n = ESC_DIG;
					skip = 1'b1;
				end else begin
					p    = flush_p(p, ph_n, hd_n, fv);
					ph_n = ESC_NONE;
				end
			end else if (ph_n == ESC_DIG) begin
				if (is_hex(fc)) begin
					p    = put(p, mk_res({hex_val(hd_n), hex_val(fc)}, 1'b1, fv, 1'b0));
					ph_n = ESC_NONE;
					skip = 1'b1;
				end else begin
					p    = flush_p(p, ph_n, hd_n, fv);
					ph_n = ESC_NONE;
				end
			end else begin
				ph_n = ESC_NONE;
			end
			if (!skip) begin
				if (fc == ChPct)
					ph_n = ESC_PCT;
				else
					p = put(p, mk_res(fc, 1'b1, fv, 1'b0));
			end
		end

		if (do_fb) begin
			p    = flush_p(p, ph_n, hd_n, form_mode_q & se_n);
			ph_n = ESC_NONE;
		end
		if (ep1) begin
			p    = end_pair(p, se_n);
			se_n = 1'b0;
		end
		if (ep2) begin
			p    = end_pair(p, se_n);
			se_n = 1'b0;
		end

		// end of string: back to the start-of-string state
		if (last) begin
			ph_n = ESC_NONE;
			hd_n = 8'h00;
			se_n = 1'b0;
			ps_n = 1'b0;
			st_n = 1'b1;
		end else begin
			ps_n = form_mode_q & is_sep;
			st_n = 1'b0;
		end
		plan = p;
	end

	assign push = acc && (plan.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_mode_q <= 1'b1;
			esc_q       <= ESC_NONE;
			held_q      <= 8'h00;
			saw_eq_q    <= 1'b0;
			prev_sep_q  <= 1'b0;
			at_start_q  <= 1'b1;
		end else begin
			if (cfg_valid)
				form_mode_q <= cfg_data;
			if (acc) begin
				esc_q      <= ph_n;
				held_q     <= hd_n;
				saw_eq_q   <= se_n;
				prev_sep_q <= ps_n;
				at_start_q <= st_n;
			end
		end
	end

	a_plan_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> plan.cnt <= CntW'(MaxRes))
		else $error("result plan overflows");

	a_string_end: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last |=> at_start_q && esc_q == ESC_NONE && !saw_eq_q && !prev_sep_q)
		else $error("state not cleared after end of string");

endmodule

// ===== src/fud_queue.sv =====
// Short queue of result plans between front and back end.
// Depends on fud_pkg.
module fud_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fud_pkg::plan_t      plan,
	input  logic                pop,
	output logic                ready,
	output fud_pkg::q_status_t  status
);
	import fud_pkg::*;

	plan_t            mem_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QPtrW:0]   cnt_q;

	assign ready         = cnt_q != (QPtrW + 1)'(QDepth);
	assign status.valid  = cnt_q != '0;
	assign status.head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= plan;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPtrW'(1);
			if (pop)
				rd_q <= rd_q + QPtrW'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QPtrW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPtrW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready || pop)
		else $error("push into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> status.valid)
		else $error("pop from empty queue");

endmodule

// ===== src/fud_back.sv =====
// Back end: walks the head plan one result per beat onto the output stream.
// Depends on fud_pkg.
module fud_back (
	input  logic               clk,
	input  logic               arst_n,
	input  fud_pkg::q_status_t status,
	input  logic               m_tready,
	output logic               pop,
	output logic               m_tvalid,
	output logic [15:0]        m_tdata,
	output logic               m_tuser,
	output logic               m_tlast
);
	import fud_pkg::*;

	logic [CntW-1:0] idx_q;
	result_t         cur;
	logic            is_last;

	assign cur      = status.head.res[idx_q];
	assign is_last  = idx_q == (status.head.cnt - CntW'(1));
	assign m_tvalid = status.valid;
	assign m_tdata  = {6'b0, cur.pend, cur.has, cur.data};
	assign m_tuser  = cur.val;
	assign m_tlast  = is_last;
	assign pop      = status.valid && m_tready && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (status.valid && m_tready) begin
			idx_q <= is_last ? '0 : idx_q + CntW'(1);
		end
	end

	a_idx_in_plan: assert property (@(posedge clk) disable iff (!arst_n)
		status.valid |-> idx_q < status.head.cnt)
		else $error("result index beyond plan");

endmodule

// ===== src/form_urlencoded_decoder.sv =====
// A taken byte's plan is written into the plan queue; its result beats are offered from the queue head.
// Throughput: one input byte per cycle while the plan queue has room; the output moves
// one result per beat, so a byte that causes k results takes k output beats (k = 0..4).
// A four-entry plan queue lets input run ahead while the output is stalled.
// Reset (arst_n low, asynchronous): form_mode = 1, queue empty, decoder at the
// start of a string with no escape pending.
// Top level of the streaming form/percent decoder; uses fud_pkg, fud_front,
// fud_queue and fud_back.
module form_urlencoded_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: form_mode
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_string
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] has_byte, [9] pair_end, rest zero
	output logic        m_tuser,   // [0] in_value
	output logic        m_tlast    // last_of_run
);
	import fud_pkg::*;

	logic      acc;
	logic      push;
	logic      pop;
	plan_t     plan;
	q_status_t status;

	// Configuration is always taken; it is to change only between strings (not enforced here).
	assign cfg_ready = 1'b1;
	// Take a byte whenever the queue has room for its plan.
	assign acc       = s_tvalid && s_tready;

	fud_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.data_byte (s_tdata),
		.last      (s_tlast),
		.push      (push),
		.plan      (plan)
	);

	fud_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.plan   (plan),
		.pop    (pop),
		.ready  (s_tready),
		.status (status)
	);

	fud_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.m_tready (m_tready),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output beat changed");

	a_empty_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> !pop)
		else $error("plan retired without a beat");

endmodule

// ===== verif/tb_form_urlencoded_decoder.sv =====
// Self-checking testbench of the streaming form/percent decoder.
// Drives raw bytes and mode writes, predicts or hand-writes every result beat; needs only src/fud_pkg.sv
// and the RTL of form_urlencoded_decoder.
`timescale 1ns / 100ps

module tb_form_urlencoded_decoder;
	import fud_pkg::*;

	localparam int ItemsTotal = 370;    // stop stimulus once this many bytes went in
	localparam int HoldCycles = 240;    // one long receiver stall to fill the plan queue
	localparam int DrainWait  = 12;     // slack for stray beats to show up once none are owed
	localparam int CycleLimit = 500000;

	// Escape scanner of the predictor; it has three phases.
	typedef enum logic [1:0] {EscNone, EscPct, EscDigit} esc_t;

	// One decoded beat as it should appear on the output stream.
	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       val;
		logic       pend;
		logic       last;
	} beat_t;

	// Directed row: mode to run in, raw byte, end of string, and an optional
	// hand-written expectation (zero or one beat) that replaces the prediction.
	typedef struct {
		logic       mode;
		logic [7:0] ch;
		logic       eos;
		logic       typed;
		logic       t_n;
		logic [7:0] t_data;
		logic       t_has;
		logic       t_val;
		logic       t_pend;
	} row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data  = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// Decoder state mirrored by the predictor.
	logic       pm_mode  = 1'b1;
	esc_t       pm_esc   = EscNone;
	logic [7:0] pm_digit = 8'h00;
	logic       pm_eq    = 1'b0;
	logic       pm_sep   = 1'b0;
	logic       pm_start = 1'b1;

	beat_t      step_res[$];     // beats caused by the byte just taken
	beat_t      decoded_q[$];    // beats still owed by the block, oldest first
	logic [7:0] str_q[$];        // random string under construction

	int   mism_cnt = 0;
	int   cyc      = 0;
	int   sent     = 0;
	logic hold_req = 1'b0;       // ask the receiver for its long stall
	logic tx_calm  = 1'b0;       // sender offers back to back while set

	row_t dir_tbl [29] = '{
		// after reset, form mode: a leading separator closes an empty pair
		'{1'b1, ChAmp,  1'b0, 1'b1, 1'b1, ChOne,   1'b1, 1'b1, 1'b1},
		// merged separator: nothing
		'{1'b1, ChSemi, 1'b0, 1'b1, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b1, "a",    1'b0, 1'b1, 1'b1, "a",     1'b1, 1'b0, 1'b0},
		// '=' opening the value: nothing
		'{1'b1, ChEq,   1'b0, 1'b1, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// plus maps to space in the value
		'{1'b1, ChPlus, 1'b0, 1'b1, 1'b1, ChSpace, 1'b1, 1'b1, 1'b0},
		// valid escape %41, held until the second digit
		'{1'b1, ChPct,  1'b0, 1'b1, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b1, "4",    1'b0, 1'b1, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b1, "1",    1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// bad escape %G passes through
		'{1'b1, ChPct,  1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b1, "G",    1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// second '=' is a plain value byte
		'{1'b1, ChEq,   1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// unfinished escape cut by a separator
		'{1'b1, ChPct,  1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b1, "f",    1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b1, ChAmp,  1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// trailing separator at end of string: one more empty pair
		'{1'b1, ChAmp,  1'b1, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// unfinished escape cut by the key/value '='
		'{1'b1, ChPct,  1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b1, ChEq,   1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// escape at the very end of the string, mixed case
		'{1'b1, ChPct,  1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b1, "f",    1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b1, "F",    1'b1, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// byte extremes
		'{1'b1, 8'hFF,  1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b1, 8'h00,  1'b1, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// path mode: plus stays literal
		'{1'b0, ChPlus, 1'b0, 1'b1, 1'b1, ChPlus,  1'b1, 1'b0, 1'b0},
		'{1'b0, ChPct,  1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b0, "2",    1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// switch to form mode mid-escape: state carries over
		'{1'b1, "B",    1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// lone '%' at end of string
		'{1'b1, ChPct,  1'b1, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		// path mode: unfinished escape at end of string
		'{1'b0, ChPct,  1'b0, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0},
		'{1'b0, "a",    1'b1, 1'b0, 1'b0, 8'h00,   1'b0, 1'b0, 1'b0}
	};

	form_urlencoded_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] data_byte
		.s_tlast   (s_tlast),   // end_of_string
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] out_byte, [8] has_byte, [9] pair_end
		.m_tuser   (m_tuser),   // [0] in_value
		.m_tlast   (m_tlast)    // last_of_run
	);

	always #5 clk = ~clk;

	// Watchdog: abort a hung run.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CycleLimit) begin
			$display("form_urlencoded_decoder: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic is_hexch(logic [7:0] c);
		return (c inside {["0":"9"], ["A":"F"], ["a":"f"]});
	endfunction

	function automatic logic [3:0] nibble_of(logic [7:0] c);
		if (c <= "9")
			return 4'(c - "0");
		return 4'((c | 8'h20) - "a" + 8'd10);
	endfunction

	function automatic void put_beat(logic [7:0] b, logic has, logic val, logic pend);
		beat_t r;
		r.data = has ? b : 8'h00;
		r.has  = has;
		r.val  = val;
		r.pend = pend;
		r.last = 1'b0;
		step_res.push_back(r);
	endfunction

	// Emit a pending '%' (and its held digit) literally.
	function automatic void flush_pct(logic val);
		if (pm_esc == EscPct) begin
			put_beat(ChPct, 1'b1, val, 1'b0);
		end else if (pm_esc == EscDigit) begin
			put_beat(ChPct, 1'b1, val, 1'b0);
			put_beat(pm_digit, 1'b1, val, 1'b0);
		end
		pm_esc = EscNone;
	endfunction

	function automatic void feed_char(logic [7:0] c, logic val);
		if (pm_esc == EscPct) begin
			if (is_hexch(c)) begin
				pm_digit = c;
				pm_esc   = EscDigit;
				return;
			end
			flush_pct(val);
		end else if (pm_esc == EscDigit) begin
			if (is_hexch(c)) begin
				put_beat({nibble_of(pm_digit), nibble_of(c)}, 1'b1, val, 1'b0);
				pm_esc = EscNone;
				return;
			end
			flush_pct(val);
		end
		if (c == ChPct)
			pm_esc = EscPct;
		else
			put_beat(c, 1'b1, val, 1'b0);
	endfunction

	// Close a pair; a pair without '=' carries the implied value '1'.
	function automatic void close_pair();
		if (pm_eq)
			put_beat(8'h00, 1'b0, 1'b1, 1'b1);
		else
			put_beat(ChOne, 1'b1, 1'b1, 1'b1);
		pm_eq = 1'b0;
	endfunction

	// Work out the beats that one raw byte causes and advance the state.
	function automatic void decode_step(logic [7:0] c, logic eos);
		step_res.delete();
		if (!pm_mode) begin
			feed_char(c, 1'b0);
			if (eos)
				flush_pct(1'b0);
			pm_sep = 1'b0;
		end else if (c == ChAmp || c == ChSemi) begin
			if (!pm_sep || pm_start) begin
				flush_pct(pm_eq);
				close_pair();
			end
			if (eos)
				close_pair();
			pm_sep = 1'b1;
		end else begin
			if (c == ChEq && !pm_eq) begin
				flush_pct(1'b0);
				pm_eq = 1'b1;
			end else begin
				feed_char((c == ChPlus) ? ChSpace : c, pm_eq);
			end
			if (eos) begin
				flush_pct(pm_eq);
				close_pair();
			end
			pm_sep = 1'b0;
		end
		pm_start = 1'b0;
		if (eos) begin
			pm_esc   = EscNone;
			pm_digit = 8'h00;
			pm_eq    = 1'b0;
			pm_sep   = 1'b0;
			pm_start = 1'b1;
		end
		if (step_res.size() > 0)
			step_res[step_res.size()-1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------- sender side

	// Offer one byte and hold it until the block takes it; predict on the beat.
	task automatic send_byte(logic [7:0] b, logic eos);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		decode_step(b, eos);
		sent++;
	endtask

	// Drop valid for a random gap: mostly none, sometimes short, rarely long.
	task automatic sender_gap();
		int r, n;
		r = $urandom_range(0, 99);
		if (tx_calm || r < 65)
			n = 0;
		else if (r < 94)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 40);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Write form_mode once the block has gone quiet.
	task automatic set_mode(logic m);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pm_mode = m;
	endtask

	// ---------------------------------------------------------------- random strings

	function automatic logic [7:0] rand_hex();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return 8'("0" + v);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
	endfunction

	function automatic void add_sep();
		str_q.push_back($urandom_range(0, 1) ? ChAmp : ChSemi);
		if ($urandom_range(0, 3) == 0)
			str_q.push_back($urandom_range(0, 1) ? ChAmp : ChSemi);
	endfunction

	// One piece of key or value text: plain, plus, equals, escapes good and bad, odd bytes.
	function automatic void add_content();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			case ($urandom_range(0, 2))
				0:       str_q.push_back(8'("a" + $urandom_range(0, 25)));
				1:       str_q.push_back(8'("A" + $urandom_range(0, 25)));
				default: str_q.push_back(8'("0" + $urandom_range(0, 9)));
			endcase
		end else if (r < 65) begin
			str_q.push_back(ChPlus);
		end else if (r < 80) begin
			str_q.push_back(ChPct);
			str_q.push_back(rand_hex());
			str_q.push_back(rand_hex());
		end else if (r < 88) begin
			str_q.push_back(ChPct);
			case ($urandom_range(0, 2))
				0: ;
				1: str_q.push_back(rand_hex());
				default: begin
					str_q.push_back(rand_hex());
					str_q.push_back("g");
				end
			endcase
		end else if (r < 92) begin
			str_q.push_back(ChEq);
		end else begin
			str_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// Mostly key=value pairs with random content; some strings are pure noise.
	function automatic void build_string();
		int np, r;
		str_q.delete();
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 12)) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					str_q.push_back(8'($urandom_range(0, 255)));
				else if (r < 55)
					str_q.push_back(ChPct);
				else if (r < 65)
					str_q.push_back(rand_hex());
				else if (r < 75)
					str_q.push_back($urandom_range(0, 1) ? ChAmp : ChSemi);
				else if (r < 85)
					str_q.push_back(ChEq);
				else
					str_q.push_back(ChPlus);
			end
		end else begin
			np = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
			if ($urandom_range(0, 9) == 0)
				add_sep();
			for (int i = 0; i < np; i++) begin
				repeat ($urandom_range(0, 3)) add_content();
				if ($urandom_range(0, 5) != 0) begin
					str_q.push_back(ChEq);
					repeat ($urandom_range(0, 3)) add_content();
				end
				if (i < np - 1 || $urandom_range(0, 5) == 0)
					add_sep();
			end
		end
		if (str_q.size() == 0)
			str_q.push_back(rand_hex());
	endfunction

	// ---------------------------------------------------------------- receiver side

	// Toggle m_tready: short stalls, a few long ones, calm stretches, and the
	// one long hold-off that backs the block up into its input.
	initial begin : rx_side
		int r, n;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_req) begin
				n = HoldCycles;
				hold_req = 1'b0;
			end else if (r < 50) begin
				n = 0;
			end else if (r < 90) begin
				n = $urandom_range(1, 3);
			end else begin
				n = $urandom_range(8, 30);
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(60, 150)) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Compare each accepted beat with the oldest owed one.
	function automatic void cmp_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mism_cnt++;
		end
	endfunction

	always @(posedge clk) begin : chk_beat
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_q.size() == 0) begin
				$error("result beat with nothing owed: tdata 0x%0h", m_tdata);
				mism_cnt++;
			end else begin
				want = decoded_q.pop_front();
				cmp_field("out_byte", want.data, m_tdata[7:0]);
				cmp_field("has_byte", want.has, m_tdata[8]);
				cmp_field("pair_end", want.pend, m_tdata[9]);
				cmp_field("tdata_pad", 0, m_tdata[15:10]);
				cmp_field("in_value", want.val, m_tuser);
				cmp_field("last_of_run", want.last, m_tlast);
			end
		end
	end

	// ---------------------------------------------------------------- main flow

	initial begin : main_flow
		beat_t tb;
		int    nstr;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; rows with a written-in expectation bypass the predictor
		// (it still runs to keep its state in step).
		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].mode != pm_mode)
				set_mode(dir_tbl[i].mode);
			send_byte(dir_tbl[i].ch, dir_tbl[i].eos);
			if (dir_tbl[i].typed) begin
				if (dir_tbl[i].t_n) begin
					tb.data = dir_tbl[i].t_data;
					tb.has  = dir_tbl[i].t_has;
					tb.val  = dir_tbl[i].t_val;
					tb.pend = dir_tbl[i].t_pend;
					tb.last = 1'b1;
					decoded_q.push_back(tb);
				end
			end else begin
				foreach (step_res[k]) decoded_q.push_back(step_res[k]);
			end
			sender_gap();
		end

		// Random strings, starting in form mode, with an occasional mode flip.
		set_mode(1'b1);
		nstr = 0;
		while (sent < ItemsTotal) begin
			if (nstr == 4)
				hold_req = 1'b1;
			if ($urandom_range(0, 99) < 10)
				set_mode(~pm_mode);
			build_string();
			tx_calm = (nstr == 4) || ($urandom_range(0, 9) == 0);
			foreach (str_q[i]) begin
				send_byte(str_q[i], i == str_q.size() - 1);
				foreach (step_res[k]) decoded_q.push_back(step_res[k]);
				sender_gap();
			end
			nstr++;
		end

		// Drain: wait for every owed beat, then let stray beats show up.
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);

		if (mism_cnt == 0)
			$display("form_urlencoded_decoder: match");
		else
			$display("form_urlencoded_decoder: mismatch");
		$finish;
	end

endmodule

// ===== form_urlencoded_decoder.f =====
src/fud_pkg.sv
src/fud_front.sv
src/fud_queue.sv
src/fud_back.sv
src/form_urlencoded_decoder.sv
verif/tb_form_urlencoded_decoder.sv
